>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication: cons must hold in the same cycle as ante.
`define PLI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define PLI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// Shared codes, state type and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package pli_pkg;

    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;
    localparam int CMD_W    = 2;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EVAL   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK             = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_INCREASING = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL           = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY          = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SATURATED      = 3'd4;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_MUL,
        S_DIV,
        S_SUM,
        S_OUT
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic exec;
        logic scan;
        logic mul;
        logic div_step;
        logic sum;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic eval_go;
        logic scan_finish;
        logic need_interp;
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/pli_ram.sv
// ----------------------------------------------------------------------------
// pli_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pli_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/pli_datapath.sv
// ----------------------------------------------------------------------------
// pli_datapath
// Breakpoint store, search registers, multiplier, restoring divider, output.
// ----------------------------------------------------------------------------
`default_nettype none

module pli_datapath import pli_pkg::*; #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [CMD_W-1:0]         command,
    input  wire logic signed [DATA_W-1:0] x_value,
    input  wire logic signed [DATA_W-1:0] f_value,
    input  wire ctrl_cmd_t                ctl,
    output dp_status_t                    sts,
    input  wire logic                     out_stall,
    output logic                          out_valid,
    output logic signed [DATA_W-1:0]      result_value,
    output logic [STATUS_W-1:0]           status
);

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRY_W = 2 * DATA_W;
    localparam int DCNT_W  = $clog2(DATA_W);

    logic [CMD_W-1:0]         cmd_reg;
    logic signed [DATA_W-1:0] x_reg;
    logic signed [DATA_W-1:0] f_reg;
    logic [CNT_W-1:0]         count_reg;
    logic signed [DATA_W-1:0] last_x_reg;
    logic [IDX_W-1:0]         chk_idx_reg;
    logic signed [DATA_W-1:0] prev_x_reg;
    logic signed [DATA_W-1:0] prev_f_reg;
    logic signed [DATA_W-1:0] lo_f_reg;
    logic [DATA_W-1:0]        dx_reg;
    logic [DATA_W-1:0]        off_reg;
    logic [DATA_W-1:0]        mag_reg;
    logic                     neg_reg;
    logic [DATA_W-1:0]        rem_reg;
    logic [DATA_W-1:0]        quo_reg;
    logic [DCNT_W-1:0]        div_cnt_reg;
    logic signed [DATA_W-1:0] res_hold_reg;
    logic [STATUS_W-1:0]      st_hold_reg;
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] result_reg;
    logic [STATUS_W-1:0]      status_reg;

    logic                     ram_we;
    logic [IDX_W-1:0]         ram_raddr;
    logic [ENTRY_W-1:0]       ram_rdata;
    logic signed [DATA_W-1:0] rd_x;
    logic signed [DATA_W-1:0] rd_f;

    logic                     app_not_inc;
    logic                     app_full;
    logic [STATUS_W-1:0]      exec_status;
    logic                     is_first;
    logic                     is_last;
    logic                     hit;
    logic signed [DATA_W:0]   dx_full;
    logic signed [DATA_W:0]   off_full;
    logic signed [DATA_W:0]   dy_full;
    logic signed [DATA_W:0]   dy_abs;
    logic [ENTRY_W-1:0]       prod;
    logic [DATA_W:0]          trial;
    logic                     trial_ge;
    logic [DATA_W:0]          trial_sub;
    logic signed [DATA_W+1:0] q_ext;
    logic signed [DATA_W+1:0] q_sgn;
    logic signed [DATA_W+1:0] sum_full;
    logic [1:0]               sum_upper;
    logic signed [DATA_W-1:0] sum_res;
    logic [STATUS_W-1:0]      sum_status;

    pli_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata ({x_reg, f_reg}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_x = $signed(ram_rdata[ENTRY_W-1:DATA_W]);
    assign rd_f = $signed(ram_rdata[DATA_W-1:0]);

    // append checks
    assign app_not_inc = (count_reg != '0) && (x_reg <= last_x_reg);
    assign app_full    = (count_reg >= CNT_W'(TABLE_DEPTH));
    assign ram_we      = ctl.exec && (cmd_reg == CMD_APPEND) && !app_not_inc && !app_full;

    always_comb
    begin
        case (cmd_reg)
            CMD_APPEND:
            begin
                if (app_not_inc)
                    exec_status = ST_NOT_INCREASING;
                else if (app_full)
                    exec_status = ST_FULL;
                else
                    exec_status = ST_OK;
            end
            CMD_EVAL:
            begin
                exec_status = (count_reg == '0) ? ST_EMPTY : ST_OK;
            end
            default:
            begin
                exec_status = ST_OK;
            end
        endcase
    end

    // read data belongs to chk_idx_reg; fetch the following entry meanwhile
    assign ram_raddr = ctl.scan ? (chk_idx_reg + IDX_W'(1)) : '0;
    assign is_first  = (chk_idx_reg == '0);
    assign is_last   = ((CNT_W'(chk_idx_reg) + CNT_W'(1)) == count_reg);
    assign hit       = is_first ? (x_reg <= rd_x) : (x_reg < rd_x);

    assign dx_full  = (DATA_W+1)'(rd_x) - (DATA_W+1)'(prev_x_reg);
    assign off_full = (DATA_W+1)'(x_reg) - (DATA_W+1)'(prev_x_reg);
    assign dy_full  = (DATA_W+1)'(rd_f) - (DATA_W+1)'(prev_f_reg);
    assign dy_abs   = dy_full[DATA_W] ? -dy_full : dy_full;

    assign prod = ENTRY_W'(off_reg) * ENTRY_W'(mag_reg);

    // restoring division step; remainder stays below dx
    assign trial     = {rem_reg, quo_reg[DATA_W-1]};
    assign trial_ge  = (trial >= {1'b0, dx_reg});
    assign trial_sub = trial - {1'b0, dx_reg};

    assign q_ext     = $signed({2'b00, quo_reg});
    assign q_sgn     = neg_reg ? -q_ext : q_ext;
    assign sum_full  = (DATA_W+2)'(lo_f_reg) + q_sgn;
    assign sum_upper = sum_full[DATA_W:DATA_W-1];

    always_comb
    begin
        if (!sum_full[DATA_W+1] && (sum_upper != 2'b00))
        begin
            sum_res    = Q_MAX;
            sum_status = ST_SATURATED;
        end
        else if (sum_full[DATA_W+1] && (sum_upper != 2'b11))
        begin
            sum_res    = Q_MIN;
            sum_status = ST_SATURATED;
        end
        else
        begin
            sum_res    = sum_full[DATA_W-1:0];
            sum_status = ST_OK;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            chk_idx_reg   <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.exec)
            begin
                chk_idx_reg <= '0;
                if (cmd_reg == CMD_CLEAR)
                    count_reg <= '0;
                else if (ram_we)
                    count_reg <= count_reg + CNT_W'(1);
            end
            if (ctl.scan && !(hit || is_last))
                chk_idx_reg <= chk_idx_reg + IDX_W'(1);
            if (ctl.mul)
                div_cnt_reg <= '0;
            else if (ctl.div_step)
                div_cnt_reg <= div_cnt_reg + DCNT_W'(1);
            if (ctl.load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.latch_in)
        begin
            cmd_reg <= command;
            x_reg   <= x_value;
            f_reg   <= f_value;
        end
        if (ram_we)
            last_x_reg <= x_reg;
        if (ctl.exec)
        begin
            res_hold_reg <= '0;
            st_hold_reg  <= exec_status;
        end
        if (ctl.scan)
        begin
            if (hit && !is_first)
            begin
                lo_f_reg <= prev_f_reg;
                dx_reg   <= dx_full[DATA_W-1:0];
                off_reg  <= off_full[DATA_W-1:0];
                mag_reg  <= dy_abs[DATA_W-1:0];
                neg_reg  <= dy_full[DATA_W];
            end
            else if (hit || is_last)
            begin
                res_hold_reg <= rd_f;
                st_hold_reg  <= ST_OK;
            end
            else
            begin
                prev_x_reg <= rd_x;
                prev_f_reg <= rd_f;
            end
        end
        if (ctl.mul)
            {rem_reg, quo_reg} <= prod;
        if (ctl.div_step)
        begin
            rem_reg <= trial_ge ? trial_sub[DATA_W-1:0] : trial[DATA_W-1:0];
            quo_reg <= {quo_reg[DATA_W-2:0], trial_ge};
        end
        if (ctl.sum)
        begin
            res_hold_reg <= sum_res;
            st_hold_reg  <= sum_status;
        end
        if (ctl.load_out)
        begin
            result_reg <= res_hold_reg;
            status_reg <= st_hold_reg;
        end
    end

    assign sts.eval_go     = (cmd_reg == CMD_EVAL) && (count_reg != '0);
    assign sts.scan_finish = hit || is_last;
    assign sts.need_interp = hit && !is_first;
    assign sts.div_last    = (div_cnt_reg == DCNT_W'(DATA_W - 1));
    assign sts.out_free    = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign result_value = result_reg;
    assign status       = status_reg;

endmodule

`default_nettype wire

>>> rtl/pli_ctrl.sv
// ----------------------------------------------------------------------------
// pli_ctrl
// Sequencer: accept, execute, scan, multiply, divide, sum, deliver.
// ----------------------------------------------------------------------------
`default_nettype none

module pli_ctrl import pli_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire dp_status_t sts,
    output ctrl_cmd_t       ctl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = sts.eval_go ? S_SCAN : S_OUT;
            end
            S_SCAN:
            begin
                if (sts.scan_finish)
                    state_next = sts.need_interp ? S_MUL : S_OUT;
            end
            S_MUL:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (sts.div_last)
                    state_next = S_SUM;
            end
            S_SUM:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (sts.out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl      = '0;
        in_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall     = 1'b0;
                ctl.latch_in = in_valid;
            end
            S_EXEC:
            begin
                ctl.exec = 1'b1;
            end
            S_SCAN:
            begin
                ctl.scan = 1'b1;
            end
            S_MUL:
            begin
                ctl.mul = 1'b1;
            end
            S_DIV:
            begin
                ctl.div_step = 1'b1;
            end
            S_SUM:
            begin
                ctl.sum = 1'b1;
            end
            S_OUT:
            begin
                ctl.load_out = sts.out_free;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/piecewise_linear_interpolator.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// Breakpoint table with clear/append/evaluate and linear interpolation.
// ----------------------------------------------------------------------------
//  channel | handshake           | word
//  --------+---------------------+---------------------------------------
//  in      | in_valid / in_stall | command, x_value, f_value
//  out     | out_valid/out_stall | result_value, status
//
//  Clear, append and unused commands go from accept through execute to output.
//  Evaluate scans k breakpoints, one per cycle through the store's read port.
//  A clamped result goes from the scan to output; interpolation adds a multiply
//  state, a 32-step restoring divider and a sum state before output.
//  Reset empties the table at once; stored entries are not cleared.
//  A new word is accepted while the previous result waits on out_stall.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module piecewise_linear_interpolator import pli_pkg::*; #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [CMD_W-1:0]         command,
    input  wire logic signed [DATA_W-1:0] x_value,
    input  wire logic signed [DATA_W-1:0] f_value,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic signed [DATA_W-1:0]      result_value,
    output logic [STATUS_W-1:0]           status
);

    ctrl_cmd_t  ctl;
    dp_status_t sts;

    pli_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .ctl      (ctl)
    );

    pli_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .command      (command),
        .x_value      (x_value),
        .f_value      (f_value),
        .ctl          (ctl),
        .sts          (sts),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .result_value (result_value),
        .status       (status)
    );

    `PLI_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "no stall after accept")
    `PLI_ASSERT_NEXT(a_load_shows_valid, ctl.load_out, out_valid, "loaded result not presented")
    `PLI_ASSERT_NEXT(a_div_then_sum, ctl.div_step && sts.div_last, ctl.sum, "no sum after divide")

endmodule

`default_nettype wire

>>> tb/piecewise_linear_interpolator_tb.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_tb
// Drives clear/append/evaluate words into the breakpoint interpolator and
// checks every result word against a behavioral table held in the bench.
// A short directed table comes first, then random table-building sessions
// with queries, under three idle patterns on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_interpolator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pli_pkg::*;

    localparam int DEPTH        = 64;
    localparam int RANDOM_WORDS = 800;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE       = 150;
    localparam int PRINT_CAP    = 40;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [STATUS_W-1:0]      code;
    } lookup_out_t;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] f;
        logic                     known;
        logic signed [DATA_W-1:0] value;
        logic [STATUS_W-1:0]      code;
    } stim_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [CMD_W-1:0]         command = CMD_CLEAR;
    logic signed [DATA_W-1:0] x_value = '0;
    logic signed [DATA_W-1:0] f_value = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DATA_W-1:0] result_value;
    logic [STATUS_W-1:0]      status;

    // bench copy of the breakpoint table
    logic signed [DATA_W-1:0] knot_x [DEPTH];
    logic signed [DATA_W-1:0] knot_f [DEPTH];
    int                       knot_count = 0;

    lookup_out_t awaited_lookups [$];
    int          error_count = 0;
    int          words_sent = 0;
    int          cycle_count = 0;
    int          gap_pct = 37;
    int          stall_pct = 50;

    localparam int DIRECTED_ROWS = 24;
    stim_row_t directed [DIRECTED_ROWS] = '{
        '{CMD_EVAL,   32'sh0000_0000, 32'sh0000_0000, 1'b1, 32'sh0, ST_EMPTY},
        '{CMD_UNUSED, Q_MAX,          Q_MIN,          1'b1, 32'sh0, ST_OK},
        '{CMD_CLEAR,  Q_MIN,          Q_MAX,          1'b1, 32'sh0, ST_OK},
        '{CMD_APPEND, Q_MIN,          Q_MIN,          1'b1, 32'sh0, ST_OK},
        '{CMD_APPEND, Q_MIN,          32'sh0000_0000, 1'b1, 32'sh0, ST_NOT_INCREASING},
        '{CMD_EVAL,   Q_MIN,          32'sh0000_0000, 1'b1, Q_MIN,  ST_OK},
        '{CMD_EVAL,   Q_MAX,          32'sh0000_0000, 1'b1, Q_MIN,  ST_OK},
        '{CMD_APPEND, -32'sh0001_0000, 32'sh0001_0000, 1'b1, 32'sh0, ST_OK},
        '{CMD_APPEND, 32'sh0002_0000, -32'sh0003_0000, 1'b1, 32'sh0, ST_OK},
        '{CMD_APPEND, Q_MAX,          Q_MAX,          1'b1, 32'sh0, ST_OK},
        '{CMD_APPEND, Q_MAX,          32'sh0000_0005, 1'b1, 32'sh0, ST_NOT_INCREASING},
        '{CMD_APPEND, -32'sh0002_0000, 32'sh0000_0000, 1'b1, 32'sh0, ST_NOT_INCREASING},
        '{CMD_EVAL,   32'sh8000_0001, 32'sh0000_0000, 1'b0, 32'sh0, ST_OK},
        '{CMD_EVAL,   -32'sh0001_0000, 32'sh0000_0000, 1'b1, 32'sh0001_0000, ST_OK},
        '{CMD_EVAL,   32'sh0000_0000, 32'sh0000_0000, 1'b0, 32'sh0, ST_OK},
        '{CMD_EVAL,   32'sh0002_0000, 32'sh0000_0000, 1'b1, -32'sh0003_0000, ST_OK},
        '{CMD_EVAL,   32'sh7FFF_FFFE, 32'sh0000_0000, 1'b0, 32'sh0, ST_OK},
        '{CMD_EVAL,   Q_MAX,          32'sh0000_0000, 1'b1, Q_MAX,  ST_OK},
        '{CMD_EVAL,   -32'sh0000_0001, 32'sh0000_0000, 1'b0, 32'sh0, ST_OK},
        '{CMD_CLEAR,  32'sh0000_0000, 32'sh0000_0000, 1'b1, 32'sh0, ST_OK},
        '{CMD_EVAL,   32'sh0000_1234, 32'sh0000_0000, 1'b1, 32'sh0, ST_EMPTY},
        '{CMD_APPEND, 32'sh0000_0000, 32'sh0000_0000, 1'b1, 32'sh0, ST_OK},
        '{CMD_APPEND, 32'sh0000_0001, Q_MIN,          1'b1, 32'sh0, ST_OK},
        '{CMD_EVAL,   32'sh0000_0000, 32'sh0000_0000, 1'b1, 32'sh0, ST_OK}
    };

    piecewise_linear_interpolator #(
        .TABLE_DEPTH (DEPTH)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .x_value      (x_value),
        .f_value      (f_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value),
        .status       (status)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic lookup_out_t interpolate(input logic signed [DATA_W-1:0] xq);
        lookup_out_t       o;
        int                seg;
        longint            lo_x, lo_f, rise_f, q, total;
        longint unsigned   offset, rise_mag, run_x, quot;
        o = '0;
        if (knot_count == 0)
        begin
            o.code = ST_EMPTY;
            return o;
        end
        if (xq <= knot_x[0])
        begin
            o.value = knot_f[0];
            return o;
        end
        seg = 1;
        while (seg < knot_count && xq >= knot_x[seg])
            seg++;
        if (seg >= knot_count)
        begin
            o.value = knot_f[knot_count-1];
            return o;
        end
        lo_x     = knot_x[seg-1];
        lo_f     = knot_f[seg-1];
        run_x    = longint'(knot_x[seg]) - lo_x;
        rise_f   = longint'(knot_f[seg]) - lo_f;
        offset   = longint'(xq) - lo_x;
        rise_mag = (rise_f < 0) ? -rise_f : rise_f;
        // both factors are below 2^32, so the product fits unsigned 64 bits
        quot  = (offset * rise_mag) / run_x;
        q     = quot;
        if (rise_f < 0)
            q = -q;
        total = lo_f + q;
        if (total > longint'(Q_MAX))
        begin
            o.value = Q_MAX;
            o.code  = ST_SATURATED;
        end
        else if (total < longint'(Q_MIN))
        begin
            o.value = Q_MIN;
            o.code  = ST_SATURATED;
        end
        else
            o.value = total[DATA_W-1:0];
        return o;
    endfunction

    function automatic lookup_out_t table_response(input logic [CMD_W-1:0] cmd,
                                                   input logic signed [DATA_W-1:0] xa,
                                                   input logic signed [DATA_W-1:0] fa);
        lookup_out_t o;
        o = '0;
        case (cmd)
            CMD_CLEAR:
                knot_count = 0;
            CMD_APPEND:
            begin
                // ordering is checked ahead of capacity
                if (knot_count > 0 && xa <= knot_x[knot_count-1])
                    o.code = ST_NOT_INCREASING;
                else if (knot_count >= DEPTH)
                    o.code = ST_FULL;
                else
                begin
                    knot_x[knot_count] = xa;
                    knot_f[knot_count] = fa;
                    knot_count++;
                end
            end
            CMD_EVAL:
                o = interpolate(xa);
            default:
                o = '0;
        endcase
        return o;
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    task automatic send_word(input logic [CMD_W-1:0] cmd,
                             input logic signed [DATA_W-1:0] xa,
                             input logic signed [DATA_W-1:0] fa,
                             input logic known = 1'b0,
                             input lookup_out_t typed_out = '0);
        lookup_out_t predicted;
        if ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < gap_pct);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        x_value  <= xa;
        f_value  <= fa;
        // hold the word until the edge that takes it
        do @(posedge clk); while (in_stall);
        predicted = table_response(cmd, xa, fa);
        awaited_lookups.push_back(known ? typed_out : predicted);
        if (cmd != CMD_UNUSED)
            words_sent++;
    endtask

    // Lower valid and hold off until every result is back; sample on the
    // falling edge so the exit does not race the result checker.
    task automatic wait_drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (awaited_lookups.size() != 0);
        @(posedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_query();
        int     k;
        longint lo, hi;
        if (knot_count == 0)
            return $urandom;
        k = $urandom_range(knot_count - 1);
        case ($urandom_range(6))
            0: return knot_x[k];
            1:
            begin
                if (k + 1 >= knot_count)
                    return knot_x[k];
                lo = knot_x[k];
                hi = knot_x[k+1];
                lo = lo + ((hi - lo) * longint'($urandom_range(1023))) / 1024;
                return lo[DATA_W-1:0];
            end
            2: return knot_x[0] - $urandom_range(64);
            3: return knot_x[knot_count-1] + $urandom_range(64);
            4: return Q_MIN;
            5: return Q_MAX;
            default: return $urandom;
        endcase
    endfunction

    // One table-building session: optional clear, sorted appends with an occasional non-increasing one, then queries.
    task automatic run_session(input int points, input int extra, input int spread);
        int                       xs [$];
        int                       base, k, evals;
        logic signed [DATA_W-1:0] ord;
        base = $urandom;
        for (k = 0; k < points + extra; k++)
        begin
            case (spread)
                0: xs.push_back($urandom);
                1: xs.push_back(base + int'($urandom_range(32'h000F_FFFF)));
                default: xs.push_back(int'($urandom_range(2000)) - 1000);
            endcase
        end
        xs.sort();
        if ($urandom_range(99) < 85 || extra > 0)
            send_word(CMD_CLEAR, $urandom, $urandom);
        for (k = 0; k < xs.size(); k++)
        begin
            if ($urandom_range(99) < 5 && knot_count > 0)
                send_word(CMD_APPEND, knot_x[knot_count-1] - $urandom_range(3), $urandom);
            ord = ($urandom_range(3) == 0) ? int'($urandom_range(255)) - 128 : $urandom;
            send_word(CMD_APPEND, xs[k], ord);
        end
        evals = $urandom_range(3, 10);
        for (k = 0; k < evals; k++)
            send_word(CMD_EVAL, pick_query(), $urandom);
    endtask

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin : check_results
        lookup_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_lookups.size() == 0)
                report_mismatch($sformatf("result %0d status %0d with nothing awaited",
                                          result_value, status));
            else
            begin
                want = awaited_lookups.pop_front();
                if (result_value !== want.value)
                    report_mismatch($sformatf("result_value %0d, want %0d",
                                              result_value, want.value));
                if (status !== want.code)
                    report_mismatch($sformatf("status %0d, want %0d", status, want.code));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        bit full_done;
        full_done = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_word(directed[r].cmd, directed[r].x, directed[r].f, directed[r].known,
                      lookup_out_t'{directed[r].value, directed[r].code});
        wait_drain();

        words_sent = 0;
        while (words_sent < RANDOM_WORDS)
        begin
            if (words_sent < RANDOM_WORDS / 3)
            begin
                gap_pct   = 37;
                stall_pct = 50;
            end
            else if (words_sent < 2 * RANDOM_WORDS / 3)
            begin
                gap_pct   = 50;
                stall_pct = 37;
            end
            else
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end

            if (!full_done)
            begin
                // fill the table to the brim, then push past it
                run_session(DEPTH, 3, 0);
                full_done = 1'b1;
                wait_drain();
            end
            else if ($urandom_range(4) == 0)
            begin
                repeat ($urandom_range(1, 4))
                    send_word(CMD_W'($urandom_range(3)), $urandom, $urandom);
            end
            else if ($urandom_range(9) == 0)
                run_session($urandom_range(13, DEPTH), 0, $urandom_range(2));
            else
                run_session($urandom_range(2, 12), 0, $urandom_range(2));
        end

        wait_drain();
        repeat (SETTLE) @(posedge clk);
        if (error_count == 0 && awaited_lookups.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
+incdir+rtl
rtl/pli_pkg.sv
rtl/pli_ram.sv
rtl/pli_datapath.sv
rtl/pli_ctrl.sv
rtl/piecewise_linear_interpolator.sv
tb/piecewise_linear_interpolator_tb.sv
